// ----- hw/rtl/rbc_pkg.sv -----
`default_nettype none
package rbc_pkg;

  // Default sizes
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;

  // Fixed field widths
  localparam int BASE_W    = 6;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE = 2'd1;

  // Base limits and reset values
  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] SRC_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] DST_BASE_RST = 6'd2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] TEN  = 8'd10;

  // Saturate a base into 2..36
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // Digit value to ASCII '0'..'9','A'..'Z'
  function automatic logic [CHAR_W-1:0] to_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dz;
    logic [CHAR_W-1:0] r;
    dz = {{(CHAR_W-BASE_W){1'b0}}, d};
    if (dz < TEN) begin
      r = CH_0 + dz;
    end else begin
      r = CH_A + dz - TEN;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rbc_ram.sv -----
`default_nettype none
module rbc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rbc_divider.sv -----
`default_nettype none
module rbc_divider #(
  parameter int VALUE_WIDTH = rbc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [VALUE_WIDTH-1:0]      dividend,
  input  wire logic [rbc_pkg::BASE_W-1:0]  divisor,
  output logic                             done_r,
  output logic      [VALUE_WIDTH-1:0]      quot_r,
  output logic      [rbc_pkg::BASE_W-1:0]  rem_r
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0]             cnt_r;
  logic [rbc_pkg::BASE_W-1:0]   divisor_r;
  logic [rbc_pkg::BASE_W:0]     shifted;
  logic                         ge;
  logic [rbc_pkg::BASE_W:0]     diff;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_r, quot_r[VALUE_WIDTH-1]};
    ge      = shifted >= {1'b0, divisor_r};
    diff    = shifted - {1'b0, divisor_r};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(VALUE_WIDTH);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in from the right as dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r    <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[VALUE_WIDTH-2:0], ge};
      rem_r  <= ge ? diff[rbc_pkg::BASE_W-1:0] : shifted[rbc_pkg::BASE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/radix_base_converter.sv -----
`default_nettype none
// Radix converter, base 2..36 in, base 2..36 out. Give one ASCII character per
// start pulse (accepted when start is high and busy is low), most significant
// first; bases outside 2..36 saturate, and characters are not checked. A
// character without in_last_char leaves busy low. The final character raises
// busy while the value is divided down by one shared restoring divider that
// retires one quotient bit per cycle: each output digit is divided off and its
// remainder stored, then every digit is read back from the digit store. A zero
// value skips the divider and keeps busy high for a single cycle. Digits come
// out most significant first, one beat per out_valid pulse, the last one
// flagged by out_last_digit. The receiver cannot stall: each beat is on the
// out_ ports for exactly one cycle and must be taken then. Write cfg_ registers
// only while idle.
module radix_base_converter #(
  parameter int VALUE_WIDTH = rbc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rbc_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbc_pkg::BASE_W-1:0]     cfg_data,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rbc_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic                           in_last_char,
  output logic                                out_valid,
  output logic      [rbc_pkg::CHAR_W-1:0]     out_digit_char,
  output logic                                out_last_digit
);

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [rbc_pkg::BASE_W-1:0]   src_base_r, dst_base_r;
  logic [VALUE_WIDTH-1:0]       acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0]       val_r, val_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rbc_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic [VALUE_WIDTH-1:0]       digit_val;
  logic [VALUE_WIDTH-1:0]       horner;
  logic                         div_start;
  logic                         div_done;
  logic [VALUE_WIDTH-1:0]       div_quot;
  logic [rbc_pkg::BASE_W-1:0]   div_rem;
  logic                         ram_we;
  logic [rbc_pkg::BASE_W-1:0]   ram_rdata;

  assign busy           = state_r != S_IDLE;
  assign accept         = start && !busy;
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= rbc_pkg::SRC_BASE_RST;
      dst_base_r <= rbc_pkg::DST_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbc_pkg::CFG_SRC_BASE: src_base_r <= cfg_data;
        rbc_pkg::CFG_DST_BASE: dst_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Character to digit value, then one Horner step
  always_comb begin
    if (in_char_code >= rbc_pkg::CH_0 && in_char_code <= rbc_pkg::CH_9) begin
      digit_val = VALUE_WIDTH'(in_char_code - rbc_pkg::CH_0);
    end else begin
      digit_val = VALUE_WIDTH'(in_char_code)
                - VALUE_WIDTH'(rbc_pkg::CH_A - rbc_pkg::TEN);
    end
    horner = acc_r * VALUE_WIDTH'(rbc_pkg::clamp_base(src_base_r)) + digit_val;
  end

  // Sequencer: accumulate, divide digit by digit, read digits back out
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_last_char) begin
            acc_nxt   = '0;
            val_nxt   = horner;
            cnt_nxt   = '0;
            state_nxt = S_CHECK;
          end else begin
            acc_nxt = horner;
          end
        end
      end
      S_CHECK: begin
        if (val_r == '0 && cnt_r == '0) begin
          // zero value: a single '0'
          out_valid_nxt = 1'b1;
          out_char_nxt  = rbc_pkg::CH_0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else if (val_r == '0 || cnt_r == CNT_W'(MAX_DIGITS)) begin
          idx_nxt   = ADDR_W'(cnt_r - 1'b1);
          state_nxt = S_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          ram_we    = 1'b1;
          val_nxt   = div_quot;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rbc_pkg::to_char(ram_rdata);
        out_last_nxt  = idx_r == '0;
        if (idx_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Shared divider by the destination base
  rbc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(val_r),
    .divisor (rbc_pkg::clamp_base(dst_base_r)),
    .done_r  (div_done),
    .quot_r  (div_quot),
    .rem_r   (div_rem)
  );

  // Remainder store, least significant digit at address 0
  rbc_ram #(
    .WIDTH(rbc_pkg::BASE_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (cnt_r[ADDR_W-1:0]),
    .wdata  (div_rem),
    .raddr  (idx_r),
    .rdata_r(ram_rdata)
  );

`ifndef SYNTHESIS
  // a beat only leaves while a conversion is running
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("output beat without a running conversion");

  // the final digit ends the conversion
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |-> !busy)
    else $error("still busy after last digit");

  // a final character always starts a conversion
  a_last_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_char) |=> busy)
    else $error("final character did not start conversion");

  // digit count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count overran store");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_radix_base_converter.sv -----
`default_nettype none
module tb_radix_base_converter;
  import rbc_pkg::*;

  localparam int                   ACC_W        = 32;
  localparam int                   DIGITS_MAX   = 32;
  localparam int                   RANDOM_ITEMS = 310;
  localparam int                   SETTLE_PAD   = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0] cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              in_last_char = 1'b0;
  logic              out_valid;
  logic [CHAR_W-1:0] out_digit_char;
  logic              out_last_digit;

  // shadow of the block's registers and running value
  logic [BASE_W-1:0] src_base_shadow = SRC_BASE_RST;
  logic [BASE_W-1:0] dst_base_shadow = DST_BASE_RST;
  logic [ACC_W-1:0]  value_shadow = '0;

  digit_beat_t       pending_digits[$];
  digit_beat_t       oldest;
  int                mismatch_count = 0;
  int                chars_sent = 0;
  bit                steady_start = 1'b0;

  radix_base_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [BASE_W-1:0] saturate_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    return (dw < TEN) ? CH_0 + dw : CH_A + dw - TEN;
  endfunction

  // fold one character into the value; on the final one, queue the converted digits
  task automatic predict_numeral_char(input logic [CHAR_W-1:0] c, input logic fin);
    logic [BASE_W-1:0] sb;
    logic [BASE_W-1:0] db;
    logic [ACC_W-1:0]  dval;
    logic [ACC_W-1:0]  v;
    logic [BASE_W-1:0] rems[DIGITS_MAX];
    int                n;
    digit_beat_t       beat;
    sb = saturate_base(src_base_shadow);
    db = saturate_base(dst_base_shadow);
    if (c >= CH_0 && c <= CH_9) dval = ACC_W'(c - CH_0);
    else dval = ACC_W'(c) - ACC_W'(CH_A) + ACC_W'(TEN);
    value_shadow = value_shadow * ACC_W'(sb) + dval;
    if (!fin) return;
    v = value_shadow;
    n = 0;
    if (v == '0) begin
      rems[0] = '0;
      n = 1;
    end else begin
      while (v != '0 && n < DIGITS_MAX) begin
        rems[n] = BASE_W'(v % ACC_W'(db));
        v = v / ACC_W'(db);
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      beat.ch = digit_ascii(rems[k]);
      beat.last = (k == 0);
      pending_digits.push_back(beat);
    end
    value_shadow = '0;
  endtask

  // send one character beat; start is left high so the next beat can follow at once
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
    if (!steady_start && $urandom_range(99) < 13) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_char_code <= c;
    in_last_char <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_numeral_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_numeral(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // drop start and wait until every digit is out and the block is idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_digits.size() == 0);
    repeat (SETTLE_PAD) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SRC_BASE) src_base_shadow = val;
    else if (idx == CFG_DST_BASE) dst_base_shadow = val;
  endtask

  // reset values: decimal in, binary out
  task automatic test_reset_values();
    send_numeral("0");
    send_numeral("255");
    settle();
  endtask

  // largest value, widest output, saturated bases, overflow
  task automatic test_base_extremes();
    write_reg(CFG_SRC_BASE, 6'd16);
    send_numeral("FFFFFFFF");
    settle();
    write_reg(CFG_SRC_BASE, 6'd0);
    write_reg(CFG_DST_BASE, 6'd63);
    // digit equal to the base is folded in unchecked
    send_numeral("121");
    settle();
    write_reg(CFG_SRC_BASE, 6'd63);
    write_reg(CFG_DST_BASE, 6'd37);
    send_numeral("ZZZZZZZ");
    settle();
    write_reg(CFG_SRC_BASE, 6'd1);
    write_reg(CFG_DST_BASE, 6'd36);
    send_numeral("1");
    settle();
  endtask

  // codes outside the digit set, incl. subtracting ones
  task automatic test_odd_characters();
    write_reg(CFG_SRC_BASE, 6'd10);
    write_reg(CFG_DST_BASE, 6'd10);
    write_reg(CFG_UNUSED, 6'd5);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_numeral("!");
    send_numeral("a");
    settle();
  endtask

  task automatic test_random_numerals();
    int                numerals;
    int                len;
    logic [BASE_W-1:0] sb;
    logic [CHAR_W-1:0] c;
    numerals = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      if (numerals % 6 == 0) begin
        settle();
        steady_start = (numerals >= 24 && numerals < 42);
        if ($urandom_range(3) == 0) write_reg(CFG_SRC_BASE, BASE_W'($urandom_range(0, 63)));
        else write_reg(CFG_SRC_BASE, BASE_W'($urandom_range(2, 36)));
        if ($urandom_range(3) == 0) write_reg(CFG_DST_BASE, BASE_W'($urandom_range(0, 63)));
        else write_reg(CFG_DST_BASE, BASE_W'($urandom_range(2, 36)));
      end
      sb = saturate_base(src_base_shadow);
      len = ($urandom_range(4) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 15) c = CHAR_W'($urandom_range(0, 255));
        else c = digit_ascii(BASE_W'($urandom_range(0, sb - 1)));
        send_char(c, i == len - 1);
      end
      numerals++;
    end
    steady_start = 1'b0;
    settle();
  endtask

  // compare each digit beat with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_digits.size() == 0) begin
        report($sformatf("unexpected digit %h last=%b", out_digit_char, out_last_digit));
      end else begin
        oldest = pending_digits.pop_front();
        if (out_digit_char !== oldest.ch)
          report($sformatf("digit_char %h, want %h", out_digit_char, oldest.ch));
        if (out_last_digit !== oldest.last)
          report($sformatf("last_digit %b, want %b", out_last_digit, oldest.last));
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_base_extremes();
    test_odd_characters();
    test_random_numerals();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_ram.sv
hw/rtl/rbc_divider.sv
hw/rtl/radix_base_converter.sv
dv/tb_radix_base_converter.sv
